// ===== sv/ccpg_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpg_pkg
// Shared types, codes and constants of the character cell pixel generator.
// ----------------------------------------------------------------------------
package ccpg_pkg;

    localparam int TEXT_COLUMNS_DEF     = 40;
    localparam int TEXT_ROWS_DEF        = 25;
    localparam int ATTRIBUTE_OFFSET_DEF = 2048;
    localparam int MAX_PIXEL_REPEAT_DEF = 8;

    localparam int ADDR_W      = 12;
    localparam int DATA_W      = 8;
    localparam int ROW_W       = 9;
    localparam int COL_W       = 6;
    localparam int COLOR_W     = 4;
    localparam int REPEAT_W    = 4;
    localparam int GLYPH_LINES = 8;
    localparam int LINE_LO_W   = 3;
    localparam int MEM_DEPTH   = 4096;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0] {
        OP_VIDEO_WR = 2'd0,
        OP_GLYPH_WR = 2'd1,
        OP_RENDER   = 2'd2
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PIXEL_REPEAT     = 2'd0,
        CFG_FIRST_CANVAS_ROW = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_VIDEO_WR = 2'd0,
        CMD_GLYPH_WR = 2'd1,
        CMD_RENDER   = 2'd2
    } cmd_kind_t;

    // address: write address, or character address of a render
    typedef struct packed {
        cmd_kind_t             kind;
        logic [ADDR_W-1:0]     address;
        logic [DATA_W-1:0]     data;
        logic [ADDR_W-1:0]     attr_addr;
        logic [LINE_LO_W-1:0]  line_lo;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  glyph;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } cell_t;

    localparam logic [COLOR_W-1:0] COLOR_MAP [8] = '{
        4'd0, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

endpackage

// ===== sv/ccpg_front.sv =====
// ----------------------------------------------------------------------------
// ccpg_front
// Classifies requests: memory writes pass on, renders get their cell and
// attribute addresses, and out-of-canvas or unused requests are dropped.
// ----------------------------------------------------------------------------
module ccpg_front #(
    parameter int TEXT_COLUMNS     = ccpg_pkg::TEXT_COLUMNS_DEF,
    parameter int TEXT_ROWS        = ccpg_pkg::TEXT_ROWS_DEF,
    parameter int ATTRIBUTE_OFFSET = ccpg_pkg::ATTRIBUTE_OFFSET_DEF
) (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [ccpg_pkg::ADDR_W-1:0]   s_address,
    input  logic [ccpg_pkg::DATA_W-1:0]   s_data,
    input  logic [ccpg_pkg::ROW_W-1:0]    s_raster_line,
    input  logic [ccpg_pkg::COL_W-1:0]    s_column,
    input  logic [ccpg_pkg::ROW_W-1:0]    first_canvas_row,
    input  logic                          q_full,
    output logic                          q_push,
    output ccpg_pkg::cmd_t                q_cmd
);

    localparam int CANVAS_LINES = TEXT_ROWS * ccpg_pkg::GLYPH_LINES;

    logic [ccpg_pkg::ROW_W:0]       line_diff;
    logic                           line_ok;
    logic                           col_ok;
    logic [ccpg_pkg::ADDR_W:0]      cell_full;
    logic [ccpg_pkg::ADDR_W:0]      attr_sum;
    logic                           keep;

    assign line_diff = {1'b0, s_raster_line} - {1'b0, first_canvas_row};
    assign line_ok   = !line_diff[ccpg_pkg::ROW_W]
                    && ({1'b0, line_diff[ccpg_pkg::ROW_W-1:0]} < (ccpg_pkg::ROW_W+1)'(CANVAS_LINES));
    assign col_ok    = {1'b0, s_column} < (ccpg_pkg::COL_W+1)'(TEXT_COLUMNS);

    assign cell_full = (ccpg_pkg::ADDR_W+1)'(line_diff[ccpg_pkg::ROW_W-1:ccpg_pkg::LINE_LO_W])
                     * (ccpg_pkg::ADDR_W+1)'(TEXT_COLUMNS)
                     + (ccpg_pkg::ADDR_W+1)'(s_column);
    assign attr_sum  = {1'b0, cell_full[ccpg_pkg::ADDR_W-1:0]}
                     + (ccpg_pkg::ADDR_W+1)'(ATTRIBUTE_OFFSET);

    always_comb begin
        q_cmd.kind      = ccpg_pkg::CMD_RENDER;
        q_cmd.address   = s_address;
        q_cmd.data      = s_data;
        q_cmd.attr_addr = attr_sum[ccpg_pkg::ADDR_W-1:0];
        q_cmd.line_lo   = line_diff[ccpg_pkg::LINE_LO_W-1:0];
        keep            = 1'b0;
        unique case (s_opcode)
            ccpg_pkg::OP_VIDEO_WR: begin
                q_cmd.kind = ccpg_pkg::CMD_VIDEO_WR;
                keep       = 1'b1;
            end
            ccpg_pkg::OP_GLYPH_WR: begin
                q_cmd.kind = ccpg_pkg::CMD_GLYPH_WR;
                keep       = 1'b1;
            end
            ccpg_pkg::OP_RENDER: begin
                q_cmd.address = cell_full[ccpg_pkg::ADDR_W-1:0];
                keep          = line_ok && col_ok;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && keep;

endmodule

// ===== sv/ccpg_queue.sv =====
// ----------------------------------------------------------------------------
// ccpg_queue
// Short command queue between the classifier and the fetch pipeline.
// ----------------------------------------------------------------------------
module ccpg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ccpg_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output ccpg_pkg::cmd_t head_cmd
);

    ccpg_pkg::cmd_t                  entry_reg [ccpg_pkg::QUEUE_DEPTH];
    logic [ccpg_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ccpg_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ccpg_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            do_pop;

    assign full       = count_reg == ccpg_pkg::QCNT_W'(ccpg_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/ccpg_fetch.sv =====
// ----------------------------------------------------------------------------
// ccpg_fetch
// Executes memory writes and fetches character, attribute and glyph row for
// renders in a lockstep pipeline that stalls as a whole.
// ----------------------------------------------------------------------------
module ccpg_fetch (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  ccpg_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            cell_valid,
    output ccpg_pkg::cell_t cell_data,
    input  logic            cell_load
);

    logic [ccpg_pkg::DATA_W-1:0]    video_mem [ccpg_pkg::MEM_DEPTH];
    logic [ccpg_pkg::DATA_W-1:0]    glyph_mem [ccpg_pkg::MEM_DEPTH];

    logic                           adv;
    logic                           video_we;
    logic                           glyph_we;
    logic                           s1_valid_reg;
    logic [ccpg_pkg::DATA_W-1:0]    char_reg;
    logic [ccpg_pkg::DATA_W-1:0]    attr_reg;
    logic [ccpg_pkg::LINE_LO_W-1:0] line_lo_reg;
    logic [ccpg_pkg::ADDR_W-1:0]    glyph_addr;
    logic                           s2_valid_reg;
    ccpg_pkg::cell_t                cell_reg;

    assign adv      = !s2_valid_reg || cell_load;
    assign q_pop    = q_valid && adv;
    assign video_we = q_pop && (q_cmd.kind == ccpg_pkg::CMD_VIDEO_WR);
    assign glyph_we = q_pop && (q_cmd.kind == ccpg_pkg::CMD_GLYPH_WR);

    assign glyph_addr = {attr_reg[7], char_reg, line_lo_reg};

    assign cell_valid = s2_valid_reg;
    assign cell_data  = cell_reg;

    always_ff @(posedge aclk) begin
        if (video_we) begin
            video_mem[q_cmd.address] <= q_cmd.data;
        end
        if (adv) begin
            char_reg    <= video_mem[q_cmd.address];
            attr_reg    <= video_mem[q_cmd.attr_addr];
            line_lo_reg <= q_cmd.line_lo;
        end
    end

    always_ff @(posedge aclk) begin
        if (glyph_we) begin
            glyph_mem[q_cmd.address] <= q_cmd.data;
        end
        if (adv) begin
            cell_reg.glyph <= glyph_mem[glyph_addr];
            cell_reg.fg    <= ccpg_pkg::COLOR_MAP[attr_reg[6:4]];
            cell_reg.bg    <= ccpg_pkg::COLOR_MAP[attr_reg[2:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= q_pop && (q_cmd.kind == ccpg_pkg::CMD_RENDER);
            s2_valid_reg <= s1_valid_reg;
        end
    end

    a_no_write_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |-> !(video_we || glyph_we))
        else $error("memory write while fetch pipeline stalled");

    a_cell_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !cell_load) |=> (s2_valid_reg && $stable(cell_reg)))
        else $error("fetched cell changed before it was taken");

    a_s2_from_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !s1_valid_reg) |=> !s2_valid_reg)
        else $error("cell valid without a fetch behind it");

endmodule

// ===== sv/ccpg_emit.sv =====
// ----------------------------------------------------------------------------
// ccpg_emit
// Serializes one glyph row into output pixels, each repeated, with the
// final pixel of the cell flagged.
// ----------------------------------------------------------------------------
module ccpg_emit #(
    parameter int MAX_PIXEL_REPEAT = ccpg_pkg::MAX_PIXEL_REPEAT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [ccpg_pkg::REPEAT_W-1:0]   pixel_repeat,
    input  logic                            cell_valid,
    input  ccpg_pkg::cell_t                 cell_data,
    output logic                            cell_load,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ccpg_pkg::COLOR_W-1:0]    m_pixel_color,
    output logic                            m_last_pixel
);

    logic [ccpg_pkg::REPEAT_W-1:0]  rep_eff;
    logic                           busy_reg, busy_next;
    ccpg_pkg::cell_t                cell_reg;
    logic [2:0]                     bit_reg, bit_next;
    logic [ccpg_pkg::REPEAT_W-2:0]  rep_cnt_reg, rep_cnt_next;
    logic                           m_valid_reg, m_valid_next;
    logic [ccpg_pkg::COLOR_W-1:0]   color_reg;
    logic                           last_reg;
    logic                           out_free;
    logic                           emit;
    logic                           rep_done;
    logic                           pix_last;

    always_comb begin
        if (pixel_repeat == '0) begin
            rep_eff = ccpg_pkg::REPEAT_W'(1);
        end else if (pixel_repeat > ccpg_pkg::REPEAT_W'(MAX_PIXEL_REPEAT)) begin
            rep_eff = ccpg_pkg::REPEAT_W'(MAX_PIXEL_REPEAT);
        end else begin
            rep_eff = pixel_repeat;
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = busy_reg && out_free;
    assign rep_done  = {1'b0, rep_cnt_reg} == rep_eff - 1'b1;
    assign pix_last  = (bit_reg == 3'd7) && rep_done;
    assign cell_load = cell_valid && (!busy_reg || (emit && pix_last));

    always_comb begin
        busy_next    = busy_reg;
        bit_next     = bit_reg;
        rep_cnt_next = rep_cnt_reg;
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            if (rep_done) begin
                rep_cnt_next = '0;
                bit_next     = bit_reg + 1'b1;
            end else begin
                rep_cnt_next = rep_cnt_reg + 1'b1;
            end
            if (pix_last) begin
                busy_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cell_load) begin
            busy_next    = 1'b1;
            bit_next     = '0;
            rep_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            bit_reg     <= '0;
            rep_cnt_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            bit_reg     <= bit_next;
            rep_cnt_reg <= rep_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cell_load) begin
            cell_reg <= cell_data;
        end
        if (emit) begin
            color_reg <= cell_reg.glyph[bit_reg] ? cell_reg.fg : cell_reg.bg;
            last_reg  <= pix_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_color = color_reg;
    assign m_last_pixel  = last_reg;

    a_rep_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ({1'b0, rep_cnt_reg} < rep_eff))
        else $error("repeat counter beyond pixel repeat");

    a_load_starts_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_load |=> (busy_reg && bit_reg == 3'd0 && rep_cnt_reg == '0))
        else $error("cell load did not restart the serializer");

    a_last_ends_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && pix_last && !cell_valid) |=> !busy_reg)
        else $error("serializer still busy after last pixel");

endmodule

// ===== sv/character_cell_pixel_generator_core.sv =====
// ----------------------------------------------------------------------------
// character_cell_pixel_generator_core
// Text-mode character generator: video and glyph memories loaded by write
// requests, render requests turned into a stream of palette pixels.
// ----------------------------------------------------------------------------
// A write request is performed in the fetch pipeline as it leaves the
// queue. A render request inside the canvas produces 8 * pixel_repeat
// pixels (pixel_repeat clamped to 1..MAX_PIXEL_REPEAT), one per cycle from
// the pixel serializer while m_ready is high; the serializer takes the next
// cell as it emits the last pixel of the current one. A render passes the
// character/attribute read and the glyph read before its pixels appear.
// Requests are queued ahead of the fetch pipeline, so writes and renders
// are accepted while earlier pixels are still being delivered. Memory
// contents are undefined until written. Renders outside the canvas,
// out-of-range columns and unused opcodes produce no pixels.
// ----------------------------------------------------------------------------
module character_cell_pixel_generator_core #(
    parameter int TEXT_COLUMNS     = ccpg_pkg::TEXT_COLUMNS_DEF,
    parameter int TEXT_ROWS        = ccpg_pkg::TEXT_ROWS_DEF,
    parameter int ATTRIBUTE_OFFSET = ccpg_pkg::ATTRIBUTE_OFFSET_DEF,
    parameter int MAX_PIXEL_REPEAT = ccpg_pkg::MAX_PIXEL_REPEAT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ccpg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ccpg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic [ccpg_pkg::ADDR_W-1:0]       s_address,
    input  logic [ccpg_pkg::DATA_W-1:0]       s_data,
    input  logic [ccpg_pkg::ROW_W-1:0]        s_raster_line,
    input  logic [ccpg_pkg::COL_W-1:0]        s_column,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ccpg_pkg::COLOR_W-1:0]      m_pixel_color,
    output logic                              m_last_pixel
);

    logic [ccpg_pkg::REPEAT_W-1:0]  pixel_repeat_reg;
    logic [ccpg_pkg::ROW_W-1:0]     first_canvas_row_reg;

    logic            q_push;
    ccpg_pkg::cmd_t  q_push_cmd;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    ccpg_pkg::cmd_t  q_head;
    logic            cell_valid;
    ccpg_pkg::cell_t cell_data;
    logic            cell_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_repeat_reg     <= ccpg_pkg::REPEAT_W'(1);
            first_canvas_row_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ccpg_pkg::CFG_PIXEL_REPEAT: begin
                    pixel_repeat_reg <= cfg_data[ccpg_pkg::REPEAT_W-1:0];
                end
                ccpg_pkg::CFG_FIRST_CANVAS_ROW: begin
                    first_canvas_row_reg <= cfg_data[ccpg_pkg::ROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    ccpg_front #(
        .TEXT_COLUMNS     (TEXT_COLUMNS),
        .TEXT_ROWS        (TEXT_ROWS),
        .ATTRIBUTE_OFFSET (ATTRIBUTE_OFFSET)
    ) u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_address        (s_address),
        .s_data           (s_data),
        .s_raster_line    (s_raster_line),
        .s_column         (s_column),
        .first_canvas_row (first_canvas_row_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (q_push_cmd)
    );

    ccpg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    ccpg_fetch u_fetch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_cmd      (q_head),
        .q_pop      (q_pop),
        .cell_valid (cell_valid),
        .cell_data  (cell_data),
        .cell_load  (cell_load)
    );

    ccpg_emit #(
        .MAX_PIXEL_REPEAT (MAX_PIXEL_REPEAT)
    ) u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pixel_repeat  (pixel_repeat_reg),
        .cell_valid    (cell_valid),
        .cell_data     (cell_data),
        .cell_load     (cell_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

endmodule
